// ===== src/assert_macros.svh =====
// Assertion macros shared by the circular deque checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication on the rising clock edge, off while reset is asserted.
`define CDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Implication that checks on the following clock edge.
`define CDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cdq_pkg.sv =====
// Shared types, constants and index helpers for the circular deque.
// No dependencies.
package cdq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CAP_W  = $clog2(DEPTH + 1);

  localparam logic [DATA_W-1:0] DATA_ONES = {DATA_W{1'b1}};

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } cdq_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_POP_WAIT
  } cdq_state_e;

  typedef struct packed {
    cdq_op_e                   op;
    logic signed [DATA_W-1:0]  value;
  } cdq_in_t;

  typedef struct packed {
    logic                      success;
    logic signed [DATA_W-1:0]  popped_value;
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  rear_value;
    logic                      is_empty;
    logic                      is_full;
  } cdq_out_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } cdq_mem_req_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx,
                                               input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] nxt;
    nxt = CAP_W'(idx) + CAP_W'(1);
    return (nxt == cap) ? '0 : nxt[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx,
                                               input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] last;
    last = cap - CAP_W'(1);
    return (idx == '0) ? last[IDX_W-1:0] : idx - IDX_W'(1);
  endfunction

  function automatic logic [CAP_W-1:0] cap_clamp(input logic [CAP_W-1:0] v);
    if (v == '0) return CAP_W'(1);
    if (v > CAP_W'(DEPTH)) return CAP_W'(DEPTH);
    return v;
  endfunction

endpackage

// ===== src/cdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cdq_ctrl.sv =====
// Deque sequencer: indices, cached end entries, capacity and store accesses.
// Depends on cdq_pkg.
module cdq_ctrl import cdq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CAP_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  input  cdq_in_t            in_item_i,
  output logic               in_ready_o,
  input  logic               slot_free_i,
  output cdq_mem_req_t       mem_req_o,
  input  logic [DATA_W-1:0]  mem_rdata_i,
  output logic               res_valid_o,
  output cdq_out_t           res_o
);

  cdq_state_e        state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic              empty_q, empty_d;
  logic [CAP_W-1:0]  cap_q, cap_d;
  logic [DATA_W-1:0] front_q, front_d, rear_q, rear_d;
  logic              pend_front_q, pend_front_d;
  logic [DATA_W-1:0] pend_pop_q, pend_pop_d;
  logic              accept, full_now, ok;
  logic [DATA_W-1:0] popped;

  assign in_ready_o = (state_q == ST_IDLE) && slot_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full_now   = !empty_q && (idx_inc(tail_q, cap_q) == head_q);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    empty_d      = empty_q;
    cap_d        = cap_q;
    front_d      = front_q;
    rear_d       = rear_q;
    pend_front_d = pend_front_q;
    pend_pop_d   = pend_pop_q;
    mem_req_o    = '0;
    mem_req_o.wdata = in_item_i.value;
    res_valid_o  = 1'b0;
    ok           = 1'b0;
    popped       = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              res_valid_o = 1'b1;
              if (!full_now) begin
                ok           = 1'b1;
                mem_req_o.we = 1'b1;
                if (empty_q) begin
                  head_d  = '0;
                  tail_d  = '0;
                  empty_d = 1'b0;
                  front_d = in_item_i.value;
                  rear_d  = in_item_i.value;
                  mem_req_o.waddr = '0;
                end else if (in_item_i.op == OP_PUSH_FRONT) begin
                  head_d  = idx_dec(head_q, cap_q);
                  front_d = in_item_i.value;
                  mem_req_o.waddr = head_d;
                end else begin
                  tail_d  = idx_inc(tail_q, cap_q);
                  rear_d  = in_item_i.value;
                  mem_req_o.waddr = tail_d;
                end
              end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
              if (empty_q) begin
                res_valid_o = 1'b1;
                popped      = DATA_ONES;
              end else if (head_q == tail_q) begin
                res_valid_o = 1'b1;
                ok          = 1'b1;
                popped      = front_q;
                head_d      = '0;
                tail_d      = '0;
                empty_d     = 1'b1;
              end else begin
                // new end entry comes back from the store next cycle
                state_d      = ST_POP_WAIT;
                mem_req_o.re = 1'b1;
                pend_front_d = (in_item_i.op == OP_POP_FRONT);
                if (in_item_i.op == OP_POP_FRONT) begin
                  pend_pop_d      = front_q;
                  head_d          = idx_inc(head_q, cap_q);
                  mem_req_o.raddr = head_d;
                end else begin
                  pend_pop_d      = rear_q;
                  tail_d          = idx_dec(tail_q, cap_q);
                  mem_req_o.raddr = tail_d;
                end
              end
            end
            default: begin
              res_valid_o = 1'b0;
            end
          endcase
        end
      end
      ST_POP_WAIT: begin
        res_valid_o = 1'b1;
        ok          = 1'b1;
        popped      = pend_pop_q;
        if (pend_front_q) begin
          front_d = mem_rdata_i;
        end else begin
          rear_d = mem_rdata_i;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      cap_d   = cap_clamp(cfg_data_i);
      head_d  = '0;
      tail_d  = '0;
      empty_d = 1'b1;
    end

    res_o.success      = ok;
    res_o.popped_value = popped;
    res_o.front_value  = empty_d ? DATA_ONES : front_d;
    res_o.rear_value   = empty_d ? DATA_ONES : rear_d;
    res_o.is_empty     = empty_d;
    res_o.is_full      = !empty_d && (idx_inc(tail_d, cap_q) == head_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      cap_q   <= CAP_W'(DEPTH);
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      cap_q   <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q      <= front_d;
    rear_q       <= rear_d;
    pend_front_q <= pend_front_d;
    pend_pop_q   <= pend_pop_d;
  end

endmodule

// ===== src/circular_deque.sv =====
// Top level of the circular deque: sequencer, entry store and output register.
// Depends on cdq_pkg, cdq_ctrl and cdq_ram.
//
//   channel | signals                             | dir
//   cfg     | cfg_valid_i cfg_ready_o cfg_data_i  | in  (capacity)
//   in      | in_valid_i in_ready_o in_item_i     | in  (op, value)
//   out     | out_valid_o out_ready_i out_item_o  | out (result)
//
// Pushes, failed operations and a pop of the last entry need no store read.
// A pop that leaves entries behind waits in ST_POP_WAIT while the new end entry is read
// from the synchronous entry store. Front and rear entries sit in registers.
// A capacity write empties the deque; no clearing pass after reset.
// A held result blocks new transfers only while out_ready_i is low.
module circular_deque import cdq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cdq_in_t          in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cdq_out_t         out_item_o
);

  cdq_mem_req_t      mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  cdq_out_t          res;
  logic              out_valid_q;
  cdq_out_t          out_item_q;
  logic              slot_free;

  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || out_ready_i;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_ready_o  (in_ready_o),
    .slot_free_i (slot_free),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== src/cdq_checker.sv =====
// Port-level checks for the circular deque, bound to the top level.
// Depends on cdq_pkg, assert_macros.svh and circular_deque.
`include "assert_macros.svh"

module cdq_checker import cdq_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input cdq_out_t         out_item_o
);

  `CDQ_ASSERT_IMP(a_empty_ends, clk_i, rst_ni, out_valid_o && out_item_o.is_empty, (out_item_o.front_value == DATA_ONES) && (out_item_o.rear_value == DATA_ONES), "empty deque shows end entries")
  `CDQ_ASSERT_IMP(a_empty_not_full, clk_i, rst_ni, out_valid_o && out_item_o.is_empty, !out_item_o.is_full, "deque empty and full at once")
  `CDQ_ASSERT_IMP(a_failed_pop, clk_i, rst_ni, out_valid_o && !out_item_o.success && (out_item_o.popped_value != '0), out_item_o.is_empty && (out_item_o.popped_value == DATA_ONES), "refused pop with entries or bad value")
  `CDQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "stalled result changed")

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
